// ===== design/thermistor_table_linearizer_top_assert.svh =====
// assertion macros used by the RTL in ttl_back
`ifndef THERMISTOR_TABLE_LINEARIZER_TOP_ASSERT_SVH
`define THERMISTOR_TABLE_LINEARIZER_TOP_ASSERT_SVH

// same-cycle implication
`define TTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/ttl_pkg.sv =====
package ttl_pkg;
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ADC_BITS_DEF = 12;
	localparam int RES_W = 29;
	localparam int TEMP_W = 16;
	localparam int IDX_W = 6;
	localparam int PULLUP_W = 20;
	localparam int EUSED_W = 7;
	localparam int CFG_W = 20;
	localparam int STATUS_W = 3;
	localparam int CODE_W_MAX = 16;
	localparam int DIV_W = 46;

	localparam logic CFG_PULLUP = 1'b0;
	localparam logic CFG_EUSED = 1'b1;
	localparam logic [PULLUP_W-1:0] PULLUP_RST = 20'd4700;
	localparam logic [EUSED_W-1:0] EUSED_RST = 7'd61;

	localparam logic REQ_WRITE = 1'b0;

	localparam logic [STATUS_W-1:0] STS_EXACT = 3'd0;
	localparam logic [STATUS_W-1:0] STS_INTERP = 3'd1;
	localparam logic [STATUS_W-1:0] STS_COLD = 3'd2;
	localparam logic [STATUS_W-1:0] STS_HOT = 3'd3;
	localparam logic [STATUS_W-1:0] STS_INVALID = 3'd4;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_CONV = 2'd1;
	localparam logic [1:0] CMD_ZERO = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [IDX_W-1:0] idx;
		logic [RES_W-1:0] res;
		logic [TEMP_W-1:0] temp;
		logic [CODE_W_MAX-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [RES_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quot;
		logic rem_nz;
	} div_rsp_t;
endpackage

// ===== design/ttl_if.sv =====
interface ttl_sample_if import ttl_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
);
	logic valid;
	logic ready;
	logic req_type;
	logic [IDX_W-1:0] entry_index;
	logic [RES_W-1:0] entry_resistance;
	logic signed [TEMP_W-1:0] entry_temperature;
	logic [ADC_BITS-1:0] adc_code;

	modport source (output valid, req_type, entry_index, entry_resistance,
		entry_temperature, adc_code, input ready);
	modport sink (input valid, req_type, entry_index, entry_resistance,
		entry_temperature, adc_code, output ready);
endinterface

interface ttl_result_if import ttl_pkg::*;;
	logic valid;
	logic ready;
	logic signed [TEMP_W-1:0] temperature;
	logic [STATUS_W-1:0] status;

	modport source (output valid, temperature, status, input ready);
	modport sink (input valid, temperature, status, output ready);
endinterface

// ===== design/ttl_ram.sv =====
module ttl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/ttl_div.sv =====
module ttl_div import ttl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RES_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [RES_W-1:0] dvs_q;
	logic [RES_W:0]   sh;
	logic             ge;

	assign sh = {rem_q, quo_q[DIV_W-1]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? RES_W'(sh - {1'b0, dvs_q}) : sh[RES_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem_nz = |rem_q;
endmodule

// ===== design/ttl_front.sv =====
module ttl_front import ttl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ttl_sample_if.sink   sample,
	output cmd_t         cmd,
	output logic         cmd_valid,
	input  logic         cmd_ready
);
	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       in_cmd;

	// writes beyond the table are dropped here
	always_comb begin
		in_cmd.idx = sample.entry_index;
		in_cmd.res = sample.entry_resistance;
		in_cmd.temp = sample.entry_temperature;
		in_cmd.code = CODE_W_MAX'(sample.adc_code);
		if (sample.req_type == REQ_WRITE) begin
			in_cmd.kind = CMD_WRITE;
		end else if (sample.adc_code == '0) begin
			in_cmd.kind = CMD_ZERO;
		end else begin
			in_cmd.kind = CMD_CONV;
		end
	end

	assign sample.ready = count_q != 2'd2;
	assign push = sample.valid && sample.ready &&
		!(sample.req_type == REQ_WRITE && int'(sample.entry_index) >= TABLE_DEPTH);
	assign cmd_valid = count_q != 2'd0;
	assign cmd = q_q[rd_ptr_q];
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= in_cmd;
		end
	end
endmodule

// ===== design/ttl_back.sv =====
module ttl_back import ttl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmd_t                           cmd,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  logic [PULLUP_W-1:0]            pullup_ohms,
	input  logic [EUSED_W-1:0]             eused,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [RES_W+TEMP_W-1:0]        ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  logic [RES_W+TEMP_W-1:0]        ram_rdata,
	output div_req_t                       div_req,
	input  div_rsp_t                       div_rsp,
	ttl_result_if.source                   result
);
	`include "thermistor_table_linearizer_top_assert.svh"

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = PULLUP_W + ADC_BITS;
	localparam logic [ADC_BITS-1:0] FULL = '1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL = 4'd1;
	localparam logic [3:0] S_DIV1 = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_DEC = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_DIV2 = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;

	logic [3:0]                state_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             n_c;
	logic                      scan_v_s1;
	logic [CW-1:0]             idx_s1;
	logic                      start_q;
	logic [ADC_BITS-1:0]       code_q;
	logic [PW-1:0]             prod_q;
	logic [RES_W-1:0]          r_q;
	logic                      eq_found_q, hi_found_q, lo_found_q;
	logic [TEMP_W-1:0]         eq_t_q, hi_t_q, lo_t_q, t0_q, tend_q;
	logic [RES_W-1:0]          hi_res_q, lo_res_q;
	logic signed [DIV_W-1:0]   p_q;
	logic [TEMP_W-1:0]         res_t_q;
	logic [STATUS_W-1:0]       res_s_q;
	logic                      out_v_q;
	logic [TEMP_W-1:0]         out_t_q;
	logic [STATUS_W-1:0]       out_s_q;
	logic [RES_W-1:0]          v_s1;
	logic [TEMP_W-1:0]         t_s1;
	logic                      issue;
	logic signed [TEMP_W:0]    dt;
	logic signed [RES_W:0]     dr;
	logic signed [DIV_W:0]     prod2;
	logic signed [TEMP_W+1:0]  qs;
	logic [TEMP_W:0]           qmag;

	always_comb begin
		int n;
		n = int'(eused);
		if (n < 2) begin
			n = 2;
		end
		if (n > TABLE_DEPTH) begin
			n = TABLE_DEPTH;
		end
		n_c = CW'(n);
	end

	assign cmd_ready = state_q == S_IDLE;
	assign ram_we = cmd_valid && cmd_ready && cmd.kind == CMD_WRITE;
	assign ram_waddr = AW'(cmd.idx);
	assign ram_wdata = {cmd.res, cmd.temp};
	assign ram_raddr = cnt_q[AW-1:0];
	assign {v_s1, t_s1} = ram_rdata;
	assign issue = state_q == S_SCAN && cnt_q < n_c;

	assign div_req.start = start_q;
	assign div_req.dividend = (state_q == S_DIV1) ? DIV_W'({prod_q, 4'b0000})
		: (p_q[DIV_W-1] ? DIV_W'(-p_q) : DIV_W'(p_q));
	assign div_req.divisor = (state_q == S_DIV1) ? RES_W'(code_q) : RES_W'(hi_res_q - lo_res_q);

	assign dt = $signed({hi_t_q[TEMP_W-1], hi_t_q}) - $signed({lo_t_q[TEMP_W-1], lo_t_q});
	assign dr = $signed({1'b0, RES_W'(r_q - lo_res_q)});
	assign prod2 = (DIV_W+1)'(dt * dr);
	assign qmag = div_rsp.quot[TEMP_W:0];
	assign qs = p_q[DIV_W-1] ? -$signed({1'b0, qmag}) - $signed({17'd0, div_rsp.rem_nz})
		: $signed({1'b0, qmag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			scan_v_s1 <= 1'b0;
			start_q <= 1'b0;
			out_v_q <= 1'b0;
			eq_found_q <= 1'b0;
			hi_found_q <= 1'b0;
			lo_found_q <= 1'b0;
		end else begin
			start_q <= (state_q == S_MUL) || (state_q == S_MUL2);
			scan_v_s1 <= issue;
			if (state_q == S_FIN && (!out_v_q || result.ready)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.kind == CMD_ZERO) begin
							state_q <= S_FIN;
						end else if (cmd.kind == CMD_CONV) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						cnt_q <= '0;
						eq_found_q <= 1'b0;
						hi_found_q <= 1'b0;
						lo_found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (scan_v_s1) begin
						if (v_s1 == r_q) begin
							eq_found_q <= 1'b1;
						end
						if (v_s1 > r_q) begin
							hi_found_q <= 1'b1;
						end else if (v_s1 < r_q) begin
							lo_found_q <= 1'b1;
						end
						if (idx_s1 == n_c - 1'b1) begin
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					if (eq_found_q || !hi_found_q || !lo_found_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_v_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (state_q == S_IDLE && cmd_valid) begin
			code_q <= cmd.code[ADC_BITS-1:0];
			res_t_q <= '0;
			res_s_q <= STS_INVALID;
		end
		if (state_q == S_MUL) begin
			prod_q <= PW'(pullup_ohms * (FULL - code_q));
		end
		if (state_q == S_DIV1 && div_rsp.done) begin
			r_q <= (|div_rsp.quot[DIV_W-1:RES_W]) ? '1 : div_rsp.quot[RES_W-1:0];
		end
		if (state_q == S_SCAN && scan_v_s1) begin
			if (v_s1 == r_q && !eq_found_q) begin
				eq_t_q <= t_s1;
			end
			if (v_s1 > r_q) begin
				hi_res_q <= v_s1;
				hi_t_q <= t_s1;
			end else if (v_s1 < r_q && !lo_found_q) begin
				lo_res_q <= v_s1;
				lo_t_q <= t_s1;
			end
			if (idx_s1 == '0) begin
				t0_q <= t_s1;
			end
			tend_q <= t_s1;
		end
		if (state_q == S_DEC) begin
			if (eq_found_q) begin
				res_t_q <= eq_t_q;
				res_s_q <= STS_EXACT;
			end else if (!hi_found_q) begin
				res_t_q <= t0_q;
				res_s_q <= STS_COLD;
			end else if (!lo_found_q) begin
				res_t_q <= tend_q;
				res_s_q <= STS_HOT;
			end
		end
		if (state_q == S_MUL2) begin
			p_q <= prod2[DIV_W-1:0];
		end
		if (state_q == S_DIV2 && div_rsp.done) begin
			res_t_q <= TEMP_W'($signed({lo_t_q[TEMP_W-1], lo_t_q[TEMP_W-1], lo_t_q}) + qs);
			res_s_q <= STS_INTERP;
		end
		if (state_q == S_FIN && (!out_v_q || result.ready)) begin
			out_t_q <= res_t_q;
			out_s_q <= res_s_q;
		end
	end

	assign result.valid = out_v_q;
	assign result.temperature = out_t_q;
	assign result.status = out_s_q;

	`TTL_ASSERT_IMP(a_div_free, clk, arst_n, start_q, !div_rsp.busy)
	`TTL_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == S_SCAN, cnt_q <= n_c)
	`TTL_ASSERT_IMP(a_bracket, clk, arst_n, state_q == S_MUL2, hi_found_q && lo_found_q && hi_res_q > lo_res_q)
	`TTL_ASSERT_IMP(a_out_from_fin, clk, arst_n, $rose(out_v_q), $past(state_q == S_FIN))
endmodule

// ===== design/thermistor_table_linearizer_top.sv =====
// Thermistor linearizer: a table-write request stores one resistance/temperature
// pair (resistances descending by index) and gives no result; a convert request
// turns an ADC code into resistance = pullup*(full-scale-code)/code in Q25.4 and
// looks it up, returning the exact entry, a linear interpolation between its
// neighbours, a clamped end entry, or status 4 for code zero. Requests queue two
// deep ahead of a sequencer that handles one at a time. With n = entries_used
// clamped to 2..TABLE_DEPTH, an interpolated convert runs two 46-step serial
// divisions that share one divider and a scan of n entries through a registered
// RAM port, plus control states. An exact or clamped result skips the second
// division; code zero skips both divisions and the scan.
module thermistor_table_linearizer_top import ttl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	ttl_sample_if.sink        sample,
	ttl_result_if.source      result
);
	logic [PULLUP_W-1:0]            pullup_q;
	logic [EUSED_W-1:0]             eused_q;
	cmd_t                           cmd;
	logic                           cmd_valid;
	logic                           cmd_ready;
	logic                           ram_we;
	logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr;
	logic [RES_W+TEMP_W-1:0]        ram_wdata;
	logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr;
	logic [RES_W+TEMP_W-1:0]        ram_rdata;
	div_req_t                       div_req;
	div_rsp_t                       div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pullup_q <= PULLUP_RST;
			eused_q <= EUSED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PULLUP: pullup_q <= cfg_wdata[PULLUP_W-1:0];
				CFG_EUSED: eused_q <= cfg_wdata[EUSED_W-1:0];
				default: ;
			endcase
		end
	end

	ttl_front #(.TABLE_DEPTH(TABLE_DEPTH), .ADC_BITS(ADC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .sample(sample),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	ttl_ram #(.WIDTH(RES_W + TEMP_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	ttl_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	ttl_back #(.TABLE_DEPTH(TABLE_DEPTH), .ADC_BITS(ADC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .pullup_ohms(pullup_q), .eused(eused_q),
		.ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
		.div_req(div_req), .div_rsp(div_rsp), .result(result)
	);
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import ttl_pkg::*;

	localparam logic REQ_CONVERT = 1'b1;
	localparam logic [RES_W-1:0] RES_MAX = '1;
	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [STATUS_W-1:0] status;
	} reading_t;

	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] idx;
		logic [RES_W-1:0] res;
		logic [TEMP_W-1:0] temp;
		logic [11:0] code;
		logic typed;
		logic [TEMP_W-1:0] want_temp;
		logic [STATUS_W-1:0] want_status;
	} stim_row_t;

	localparam int N_ROWS = 15;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'd0, 1'b1, 16'd0, STS_INVALID},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'd1, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'hFFF, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'h800, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'hAAA, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'h555, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'hFFE, 1'b0, 16'd0, STS_EXACT},
		'{REQ_WRITE, 6'd63, 29'h1FFFFFFF, 16'h8000, 12'd0, 1'b0, 16'd0, STS_EXACT},
		'{REQ_WRITE, 6'h2A, 29'h0AAAAAAA, 16'h5555, 12'hFFF, 1'b0, 16'd0, STS_EXACT},
		'{REQ_WRITE, 6'h15, 29'h15555555, 16'hAAAA, 12'd0, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'h7FF, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'd100, 1'b0, 16'd0, STS_EXACT},
		'{REQ_WRITE, 6'd0, 29'd0, 16'h7FFF, 12'd0, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'd1, 1'b0, 16'd0, STS_EXACT},
		'{REQ_CONVERT, 6'd0, 29'd0, 16'd0, 12'd0, 1'b1, 16'd0, STS_INVALID}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	ttl_sample_if sample_if();
	ttl_result_if result_if();

	thermistor_table_linearizer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample(sample_if),
		.result(result_if)
	);

	logic [RES_W-1:0] tab_res [DEPTH];
	logic signed [TEMP_W-1:0] tab_temp [DEPTH];
	logic [PULLUP_W-1:0] pullup_cfg;
	logic [EUSED_W-1:0] eused;
	reading_t pending_readings [$];
	int errors = 0;
	int readings_seen = 0;
	bit sender_calm = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [RES_W-1:0] resistance_of(input logic [11:0] code);
		longint unsigned r;
		r = longint'(pullup_cfg) * (4095 - code) * 16 / code;
		return (r > RES_MAX) ? RES_MAX : r[RES_W-1:0];
	endfunction

	function automatic reading_t linearise(input logic [11:0] code);
		reading_t o;
		logic [RES_W-1:0] r;
		int n, hi, lo;
		bit have_hi, have_lo;
		longint p, d, q;
		have_hi = 0;
		have_lo = 0;
		hi = 0;
		lo = 0;
		if (code == 0) begin
			o.temp = 0;
			o.status = STS_INVALID;
			return o;
		end
		r = resistance_of(code);
		n = (eused < 2) ? 2 : (eused > DEPTH) ? DEPTH : eused;
		for (int i = 0; i < n; i++) begin
			if (tab_res[i] == r) begin
				o.temp = tab_temp[i];
				o.status = STS_EXACT;
				return o;
			end
			if (tab_res[i] > r) begin
				hi = i;
				have_hi = 1;
			end else if (!have_lo) begin
				lo = i;
				have_lo = 1;
			end
		end
		if (!have_hi) begin
			o.temp = tab_temp[0];
			o.status = STS_COLD;
		end else if (!have_lo) begin
			o.temp = tab_temp[n-1];
			o.status = STS_HOT;
		end else begin
			p = (longint'(tab_temp[hi]) - longint'(tab_temp[lo]))
				* (longint'(r) - longint'(tab_res[lo]));
			d = longint'(tab_res[hi]) - longint'(tab_res[lo]);
			q = p / d;
			if (p % d != 0 && p < 0)
				q -= 1;
			o.temp = TEMP_W'(longint'(tab_temp[lo]) + q);
			o.status = STS_INTERP;
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx,
		input logic [RES_W-1:0] res, input logic [TEMP_W-1:0] temp,
		input logic [11:0] code, input logic typed = 0,
		input logic [TEMP_W-1:0] want_temp = 0, input logic [STATUS_W-1:0] want_status = 0);
		int gap;
		reading_t rd;
		sample_if.valid <= 1;
		sample_if.req_type <= kind;
		sample_if.entry_index <= idx;
		sample_if.entry_resistance <= res;
		sample_if.entry_temperature <= temp;
		sample_if.adc_code <= code;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		if (kind == REQ_WRITE) begin
			tab_res[idx] = res;
			tab_temp[idx] = temp;
		end else begin
			rd = linearise(code);
			if (typed) begin
				rd.temp = want_temp;
				rd.status = want_status;
			end
			pending_readings.push_back(rd);
		end
		gap = sender_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			sample_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		sample_if.valid <= 0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [PULLUP_W-1:0] pu, input logic [EUSED_W-1:0] eu);
		cfg_we <= 1;
		cfg_index <= CFG_PULLUP;
		cfg_wdata <= pu;
		@(posedge clk);
		cfg_index <= CFG_EUSED;
		cfg_wdata <= CFG_W'(eu);
		@(posedge clk);
		cfg_we <= 0;
		pullup_cfg = pu;
		eused = eu;
	endtask

	task automatic fill_table(input bit fixed);
		longint r;
		int t;
		r = RES_MAX;
		t = -32768 + $urandom_range(0, 2000);
		for (int i = 0; i < DEPTH; i++) begin
			if (fixed) begin
				r = (i % 2) ? ((RES_MAX >> (i / 2)) * 3 / 4) : (RES_MAX >> (i / 2));
				t = -32768 + i * 1040;
			end
			send_request(REQ_WRITE, IDX_W'(i), RES_W'(r), TEMP_W'(t), 12'($urandom));
			if (!fixed) begin
				r = r - $urandom_range(r / 8, r / 3);
				if (r < 4)
					r = 0;
				t = t + $urandom_range(0, 1000);
				if (t > 32767)
					t = 32767;
			end
		end
	endtask

	task automatic random_item;
		int sel, idx;
		logic [11:0] code;
		longint lo_r, hi_r;
		sel = $urandom_range(0, 99);
		idx = $urandom_range(0, DEPTH - 1);
		code = 12'($urandom_range(1, 4095));
		if (sel < 55) begin
			send_request(REQ_CONVERT, IDX_W'($urandom), RES_W'($urandom),
				TEMP_W'($urandom), code);
		end else if (sel < 62) begin
			code = (sel % 2) ? 12'd0 : ((sel % 3) ? 12'd1 : 12'hFFF);
			send_request(REQ_CONVERT, IDX_W'($urandom), RES_W'($urandom),
				TEMP_W'($urandom), code);
		end else if (sel < 72) begin
			send_request(REQ_WRITE,
				IDX_W'(idx % ((eused < 2) ? 2 : (eused > DEPTH) ? DEPTH : eused)),
				resistance_of(code), TEMP_W'($urandom), 12'($urandom));
			send_request(REQ_CONVERT, IDX_W'($urandom), RES_W'($urandom),
				TEMP_W'($urandom), code);
		end else if (sel < 92) begin
			hi_r = (idx > 0) ? tab_res[idx-1] : RES_MAX;
			lo_r = (idx < DEPTH - 1) ? tab_res[idx+1] : 0;
			if (lo_r > hi_r)
				{lo_r, hi_r} = {hi_r, lo_r};
			send_request(REQ_WRITE, IDX_W'(idx),
				RES_W'(lo_r + ($urandom % (hi_r - lo_r + 1))),
				TEMP_W'((longint'(tab_temp[idx > 0 ? idx - 1 : 0])
					+ longint'(tab_temp[idx])) / 2),
				12'($urandom));
		end else begin
			send_request(REQ_WRITE, IDX_W'(idx), RES_W'($urandom), TEMP_W'($urandom),
				12'($urandom));
		end
	endtask

	// receiver: random stalls, calm stretches, and one long hold-off
	initial begin
		int gap;
		reading_t want;
		result_if.ready <= 0;
		@(posedge arst_n);
		forever begin
			if (readings_seen == 150)
				gap = 2000;
			else if ((readings_seen / 100) % 3 == 0)
				gap = 0;
			else
				gap = $urandom_range(0, 7);
			if (gap > 0) begin
				result_if.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			result_if.ready <= 1;
			@(posedge clk);
			while (!result_if.valid)
				@(posedge clk);
			readings_seen++;
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected reading", result_if.temperature, 0);
			end else begin
				want = pending_readings.pop_front();
				if (result_if.temperature !== want.temp)
					report_mismatch("temperature", result_if.temperature, want.temp);
				if (result_if.status !== want.status)
					report_mismatch("status", result_if.status, want.status);
			end
		end
	end

	initial begin
		logic [PULLUP_W-1:0] phase_pullup [6];
		logic [EUSED_W-1:0] phase_eused [6];
		phase_pullup = '{PULLUP_RST, 20'd1, 20'hFFFFF, PULLUP_W'($urandom_range(1, 20'hFFFFF)),
			PULLUP_W'($urandom_range(1, 50000)), 20'd10000};
		phase_eused = '{EUSED_RST, 7'd2, 7'd64, 7'd127, 7'd0, 7'd40};
		arst_n <= 0;
		cfg_we <= 0;
		cfg_index <= CFG_PULLUP;
		cfg_wdata <= 0;
		sample_if.valid <= 0;
		sample_if.req_type <= REQ_WRITE;
		sample_if.entry_index <= 0;
		sample_if.entry_resistance <= 0;
		sample_if.entry_temperature <= 0;
		sample_if.adc_code <= 0;
		pullup_cfg = PULLUP_RST;
		eused = EUSED_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		fill_table(1);
		for (int i = 0; i < N_ROWS; i++)
			send_request(DIRECTED[i].kind, DIRECTED[i].idx, DIRECTED[i].res, DIRECTED[i].temp,
				DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].want_temp,
				DIRECTED[i].want_status);
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_config(phase_pullup[ph], phase_eused[ph]);
			sender_calm = (ph % 2) == 1;
			fill_table(0);
			for (int k = 0; k < 180; k++)
				random_item();
		end
		drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
